FILE: sv/sitda_pkg.sv
// shared types and constants for the signed integer to decimal ascii converter
// used by the controller, the datapath, the top level and the port checker
package sitda_pkg;

    localparam int MAX_LABEL   = 10;
    localparam int MAX_RESULTS = 10;
    // character limit per number, clamped to the result capacity and to two
    localparam int LIMIT = (MAX_LABEL > MAX_RESULTS) ? MAX_RESULTS :
                           ((MAX_LABEL < 2) ? 2 : MAX_LABEL);

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int STEP_W     = $clog2(VALUE_W);
    // length counters hold up to NUM_DIGITS + 1 (sign plus digits)
    localparam int LEN_W      = $clog2(NUM_DIGITS + 2);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_MEASURE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic measure;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic shift_done;
        logic out_free;
        logic emit_last;
    } t_dp_status;

endpackage

FILE: sv/signed_int_to_decimal_ascii.sv
// top level of the signed integer to decimal ascii converter
// joins sitda_ctrl and sitda_dp; uses sitda_pkg
//
// input channel: i_in_valid / o_in_stall carry one signed 32-bit i_value per
// transfer. output channel: o_out_valid / i_out_stall carry one ascii
// character per transfer, most significant first, o_last_char high on the
// final character of a number. negative numbers start with '-', zero gives
// a single '0', and at most LIMIT characters are sent (low digits dropped).
// sequence: the number is loaded, converted by a 32-step shift-add-3 binary
// to bcd loop (one bit per cycle) and its leading digit is found; then one
// character is sent per cycle while the receiver does not stall.
// o_in_stall is low only between numbers.
// when the receiver stalls, the character in the output register holds and
// emission pauses; the last character may wait there while the next number
// is already being accepted and converted.
// reset (synchronous, active low) returns the controller to idle and drops
// o_out_valid; no state carries over between numbers.
module signed_int_to_decimal_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sitda_pkg::VALUE_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sitda_pkg::CHAR_W-1:0]  o_text_char,
    output logic                          o_last_char
);
    import sitda_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sitda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    sitda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule

FILE: sv/sitda_ctrl.sv
// controller state machine: sequences load, binary to bcd shifting,
// length measurement and character emission; uses sitda_pkg
module sitda_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sitda_pkg::t_dp_status i_status,
    output sitda_pkg::t_dp_cmd    o_cmd
);
    import sitda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                o_cmd.shift = 1'b1;
                if (i_status.shift_done) begin
                    n_state = ST_MEASURE;
                end
            end
            ST_MEASURE: begin
                o_cmd.measure = 1'b1;
                n_state       = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/sitda_dp.sv
// datapath: magnitude register, shift-add-3 bcd converter, leading digit
// search, character selection and output register; uses sitda_pkg
module sitda_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [sitda_pkg::VALUE_W-1:0]   i_value,
    input  sitda_pkg::t_dp_cmd              i_cmd,
    output sitda_pkg::t_dp_status           o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sitda_pkg::CHAR_W-1:0]    o_text_char,
    output logic                            o_last_char
);
    import sitda_pkg::*;

    logic [VALUE_W-1:0]   r_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic                 r_neg;
    logic [STEP_W-1:0]    r_step;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     r_emitted;
    logic [DIG_IDX_W-1:0] r_dptr;
    logic                 r_minus;
    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_text_char;
    logic                 r_last_char;

    logic [BCD_W-1:0]     bcd_adj;
    logic [DIG_IDX_W-1:0] top_idx;
    logic [LEN_W-1:0]     total_len;
    logic [3:0]           cur_digit;
    logic [CHAR_W-1:0]    cur_char;
    logic [LEN_W-1:0]     emitted_inc;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // highest nonzero digit, zero gives position 0
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                top_idx = DIG_IDX_W'(i);
            end
        end
        total_len = LEN_W'(top_idx) + LEN_W'(1) + LEN_W'(r_neg);
    end

    always_comb begin
        cur_digit = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_dptr == DIG_IDX_W'(i)) begin
                cur_digit = r_bcd[4*i +: 4];
            end
        end
        cur_char    = r_minus ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(cur_digit));
        emitted_inc = r_emitted + LEN_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg  <= i_value[VALUE_W-1];
            r_bin  <= i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
            r_bcd  <= '0;
            r_step <= '0;
        end else if (i_cmd.shift) begin
            {r_bcd, r_bin} <= {bcd_adj[BCD_W-2:0], r_bin, 1'b0};
            r_step         <= r_step + STEP_W'(1);
        end
        if (i_cmd.measure) begin
            r_dptr    <= top_idx;
            r_minus   <= r_neg;
            r_emitted <= '0;
            r_len     <= (total_len > LEN_W'(LIMIT)) ? LEN_W'(LIMIT) : total_len;
        end else if (i_cmd.emit) begin
            r_emitted <= emitted_inc;
            if (r_minus) begin
                r_minus <= 1'b0;
            end else begin
                r_dptr <= r_dptr - DIG_IDX_W'(1);
            end
        end
        if (i_cmd.emit) begin
            r_text_char <= cur_char;
            r_last_char <= (emitted_inc == r_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.shift_done = (r_step == STEP_W'(VALUE_W - 1));
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.emit_last  = (emitted_inc == r_len);

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_text_char;
    assign o_last_char = r_last_char;

endmodule

FILE: sv/sitda_checker.sv
// port-level checker for signed_int_to_decimal_ascii, bound to the top level
// uses sitda_pkg for the character codes
module sitda_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [sitda_pkg::CHAR_W-1:0]  o_text_char,
    input logic                          o_last_char
);
    import sitda_pkg::*;

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_text_char)
            && $stable(o_last_char))
        else $error("stalled output transfer changed");

    // only a sign or a digit ever leaves
    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_text_char == CHAR_MINUS)
            || (o_text_char >= CHAR_ZERO && o_text_char <= CHAR_NINE))
        else $error("output character is not a sign or digit");

    // the sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_text_char == CHAR_MINUS) |-> !o_last_char)
        else $error("sign flagged as last character");

    // a number in conversion blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted twice in a row");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_text_char (o_text_char),
    .o_last_char (o_last_char)
);

FILE: dv/tb_signed_int_to_decimal_ascii.sv
// testbench for signed_int_to_decimal_ascii: signed numbers in, decimal text checked per character
// depends on sitda_pkg and the signed_int_to_decimal_ascii top level
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    import sitda_pkg::*;

    // characters per number after clamping the label limit
    localparam int CHAR_CAP   = (MAX_LABEL > MAX_RESULTS) ? MAX_RESULTS :
                                ((MAX_LABEL < 2) ? 2 : MAX_LABEL);
    localparam int DRAIN_WAIT = 60;
    localparam int WATCHDOG   = 2000;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 in_valid    = 1'b0;
    logic [VALUE_W-1:0]   value       = '0;
    logic                 out_stall   = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [CHAR_W-1:0]    o_text_char;
    logic                 o_last_char;

    t_text_char pending_chars[$];

    int  err_count     = 0;
    int  numbers_sent  = 0;
    int  negatives     = 0;
    int  truncated     = 0;
    int  chars_checked = 0;
    int  quiet_cycles  = 0;
    int  sink_hold_len = 0;
    bit  src_idle_on   = 1'b0;
    bit  sink_idle_on  = 1'b0;

    signed_int_to_decimal_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (value),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // decimal text of one number, clipped to the character limit
    function automatic void predict_text(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [CHAR_W-1:0]  digits [NUM_DIGITS];
        logic [CHAR_W-1:0]  text [NUM_DIGITS + 1];
        int                 ndig;
        int                 len;
        int                 n;
        t_text_char         tc;
        ndig = 0;
        len  = 0;
        mag  = v[VALUE_W-1] ? (32'd0 - v) : v;
        do begin
            digits[ndig] = CHAR_ZERO + CHAR_W'(mag % 10);
            mag          = mag / 10;
            ndig++;
        end while (mag != 0 && ndig < NUM_DIGITS);
        if (v[VALUE_W-1]) begin
            text[len] = CHAR_MINUS;
            len++;
            negatives++;
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            text[len] = digits[i];
            len++;
        end
        n = (len > CHAR_CAP) ? CHAR_CAP : len;
        if (len > n) truncated++;
        for (int i = 0; i < n; i++) begin
            tc.ch   = text[i];
            tc.last = (i == n - 1);
            pending_chars.push_back(tc);
        end
    endfunction

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR: %s", msg);
    endfunction

    // mostly numbers of a chosen digit count, plus small and full-range ones
    function automatic logic [VALUE_W-1:0] pick_value();
        longint lo;
        longint hi;
        longint m;
        int     d;
        bit     neg;
        logic [VALUE_W-1:0] v;
        neg = $urandom_range(0, 1);
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: begin
                m = $urandom_range(0, 99);
                v = neg ? VALUE_W'(-m) : VALUE_W'(m);
            end
            default: begin
                d  = $urandom_range(1, 10);
                lo = 1;
                for (int i = 1; i < d; i++) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'd2147483648) hi = 64'd2147483648;
                m = lo + (longint'($urandom) % (hi - lo + 1));
                if (m == 64'd2147483648) neg = 1'b1;
                v = neg ? VALUE_W'(-m) : VALUE_W'(m);
            end
        endcase
        return v;
    endfunction

    // offer one number, hold it until the transfer, then log its expected text
    task automatic send_number(input logic [VALUE_W-1:0] v);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_text(v);
        numbers_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [VALUE_W-1:0] vals [$];
        vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'd123456789, -32'sd123456789,
                 32'd1000000000, -32'sd1000000000, -32'sd999999999,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'd4000, -32'sd7};
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        foreach (vals[i]) send_number(vals[i]);
        wait_drained();
    endtask

    task automatic test_random();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        repeat (230) send_number(pick_value());
        wait_drained();
    endtask

    // receiver holds off long enough for the converter to fill and stall its input
    task automatic test_backpressure();
        sink_hold_len = 400;
        repeat (6) send_number(pick_value());
        wait_drained();
    endtask

    task automatic test_pause();
        repeat (2) begin
            repeat (6) send_number(pick_value());
            wait_drained();
        end
    endtask

    task automatic test_full_rate();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (80) send_number(pick_value());
        wait_drained();
    endtask

    // receiver side: random stall bursts, or one long hold when asked
    initial begin
        int stall_len;
        @(posedge i_clk);
        forever begin
            if (sink_hold_len > 0) begin
                stall_len     = sink_hold_len;
                sink_hold_len = 0;
                out_stall <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                stall_len = $urandom_range(1, 17);
                out_stall <= 1'b1;
            end else begin
                stall_len = 1;
                out_stall <= 1'b0;
            end
            repeat (stall_len) @(posedge i_clk);
        end
    end

    // compare every character transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                note_error($sformatf("unexpected char 0x%02h last=%0b",
                                     o_text_char, o_last_char));
            end else begin
                want = pending_chars.pop_front();
                if (o_text_char !== want.ch || o_last_char !== want.last)
                    note_error($sformatf("char exp 0x%02h last=%0b, got 0x%02h last=%0b",
                                         want.ch, want.last, o_text_char, o_last_char));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG);
            $display("signed_int_to_decimal_ascii verification failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        test_pause();
        test_full_rate();
        if (pending_chars.size() != 0)
            note_error($sformatf("%0d chars never arrived", pending_chars.size()));
        $display("converted %0d numbers (%0d negative, %0d clipped to %0d chars)",
                 numbers_sent, negatives, truncated, CHAR_CAP);
        $display("%0d characters checked, %0d mismatches", chars_checked, err_count);
        if (err_count == 0)
            $display("signed_int_to_decimal_ascii verification clean");
        else
            $display("signed_int_to_decimal_ascii verification failed");
        $finish;
    end

endmodule
